>>> rtl/core/smpc_pkg.sv
// ----------------------------------------------------------------------------
// smpc_pkg
// Shared types and codes of the segmented memory permission check unit.
// ----------------------------------------------------------------------------
package smpc_pkg;

    typedef enum logic [2:0] {
        CMD_RD_BYTE = 3'd0,
        CMD_RD_HALF = 3'd1,
        CMD_RD_WORD = 3'd2,
        CMD_WR_BYTE = 3'd3,
        CMD_WR_HALF = 3'd4,
        CMD_WR_WORD = 3'd5,
        CMD_FETCH   = 3'd6,
        CMD_ADD_SEG = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_MISALIGNED   = 3'd1,
        ERR_READ_DENIED  = 3'd2,
        ERR_WRITE_DENIED = 3'd3,
        ERR_NOT_EXEC     = 3'd4,
        ERR_FETCH_OOB    = 3'd5,
        ERR_TABLE_FULL   = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_LOAD  = 2'd2
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } dp_ctrl_t;

    localparam int PERM_READ_BIT  = 0;
    localparam int PERM_WRITE_BIT = 1;
    localparam int PERM_EXEC_BIT  = 2;
    localparam int BYTE_LANES     = 4;

endpackage

>>> rtl/core/smpc_ctrl.sv
// ----------------------------------------------------------------------------
// smpc_ctrl
// Request sequencer: capture, check and memory access, result load.
// ----------------------------------------------------------------------------
module smpc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output smpc_pkg::dp_ctrl_t  ctrl
);

    smpc_pkg::state_t state_reg;
    smpc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            smpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = smpc_pkg::ST_CHECK;
                end
            end
            smpc_pkg::ST_CHECK:
            begin
                ctrl.execute = 1'b1;
                state_next   = smpc_pkg::ST_LOAD;
            end
            smpc_pkg::ST_LOAD:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.publish = 1'b1;
                    state_next   = smpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smpc_pkg::ST_IDLE;
            end
        endcase

        if (ctrl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/smpc_datapath.sv
// ----------------------------------------------------------------------------
// smpc_datapath
// Request registers, segment table with parallel region match, byte-lane
// memory and result register.
// ----------------------------------------------------------------------------
module smpc_datapath #(
    parameter int ADDR_BITS   = 16,
    parameter int MAX_REGIONS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  smpc_pkg::dp_ctrl_t  ctrl,
    input  logic [2:0]          command,
    input  logic [15:0]         address,
    input  logic [31:0]         write_data,
    input  logic [15:0]         new_seg_base,
    input  logic [16:0]         new_seg_size,
    input  logic [2:0]          new_seg_perms,
    output logic [31:0]         read_data,
    output logic [2:0]          error_code
);

    localparam int AW    = ADDR_BITS;
    localparam int LW    = ADDR_BITS + 1;
    localparam int EW    = ADDR_BITS + 2;
    localparam int WAW   = ADDR_BITS - 2;
    localparam int WORDS = 2 ** WAW;
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int IW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NL    = smpc_pkg::BYTE_LANES;

    // request registers
    smpc_pkg::cmd_t   cmd_reg;
    logic [AW-1:0]    addr_reg;
    logic [31:0]      wdata_reg;
    logic [AW-1:0]    seg_base_reg;
    logic [LW-1:0]    seg_len_reg;
    logic [2:0]       seg_perms_reg;

    logic [31:0]      addr_ext;
    logic [31:0]      base_ext;
    logic [32:0]      size_ext;

    // segment table
    logic [AW-1:0]          region_base_reg  [MAX_REGIONS];
    logic [EW-1:0]          region_end_reg   [MAX_REGIONS];
    logic [2:0]             region_perms_reg [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] region_valid_reg;
    logic [CW-1:0]          region_count_reg;

    // memory, one word of four byte lanes per entry
    logic [31:0]      mem_reg [WORDS];
    logic [31:0]      rd_word_reg;
    logic [WAW-1:0]   word_idx;

    smpc_pkg::err_t   err_reg;
    smpc_pkg::err_t   err_next;
    logic [31:0]      read_data_reg;
    logic [31:0]      read_data_next;
    logic [2:0]       error_code_reg;

    logic [AW-1:0]    lane_addr  [NL];
    logic [2:0]       lane_perms [NL];
    logic [EW-1:0]    first_end;
    logic [NL-1:0]    lane_hit;
    logic [NL-1:0]    lane_rd_ok;
    logic [NL-1:0]    lane_wr_ok;
    logic [NL-1:0]    lane_mask;
    logic [NL-1:0]    mem_we;
    logic [31:0]      wlane_data;
    logic [31:0]      rd_shift;
    logic [EW-1:0]    fetch_last;
    logic             misaligned;
    logic             table_full;
    logic             region_add;
    logic             is_write;

    assign addr_ext = {16'b0, address};
    assign base_ext = {16'b0, new_seg_base};
    assign size_ext = {16'b0, new_seg_size};

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg       <= smpc_pkg::cmd_t'(command);
            addr_reg      <= addr_ext[AW-1:0];
            wdata_reg     <= write_data;
            seg_base_reg  <= base_ext[AW-1:0];
            seg_len_reg   <= size_ext[LW-1:0];
            seg_perms_reg <= new_seg_perms;
        end
    end

    // first matching region for each byte lane of the addressed word
    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            lane_addr[k]  = {addr_reg[AW-1:2], 2'(k)};
            lane_hit[k]   = 1'b0;
            lane_perms[k] = '0;
            // walk downward so the lowest index wins
            for (int i = MAX_REGIONS - 1; i >= 0; i--)
            begin
                if (region_valid_reg[i] && (lane_addr[k] >= region_base_reg[i])
                    && ({2'b00, lane_addr[k]} < region_end_reg[i]))
                begin
                    lane_hit[k]   = 1'b1;
                    lane_perms[k] = region_perms_reg[i];
                end
            end
            lane_rd_ok[k] = !lane_hit[k] || lane_perms[k][smpc_pkg::PERM_READ_BIT];
            lane_wr_ok[k] = !lane_hit[k] || lane_perms[k][smpc_pkg::PERM_WRITE_BIT];
        end
    end

    always_comb
    begin
        first_end = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--)
        begin
            if (region_valid_reg[i] && (lane_addr[0] >= region_base_reg[i])
                && ({2'b00, lane_addr[0]} < region_end_reg[i]))
            begin
                first_end = region_end_reg[i];
            end
        end
    end

    assign fetch_last = {2'b00, lane_addr[NL-1]};
    assign table_full = (region_count_reg == CW'(MAX_REGIONS));
    assign word_idx   = addr_reg[AW-1:2];
    assign wlane_data = wdata_reg << {addr_reg[1:0], 3'b000};

    always_comb
    begin
        lane_mask  = '0;
        misaligned = 1'b0;
        is_write   = 1'b0;
        err_next   = smpc_pkg::ERR_OK;
        unique case (cmd_reg) inside
            smpc_pkg::CMD_RD_BYTE, smpc_pkg::CMD_WR_BYTE:
            begin
                lane_mask = 4'b0001 << addr_reg[1:0];
            end
            smpc_pkg::CMD_RD_HALF, smpc_pkg::CMD_WR_HALF:
            begin
                lane_mask  = addr_reg[1] ? 4'b1100 : 4'b0011;
                misaligned = addr_reg[0];
            end
            smpc_pkg::CMD_RD_WORD, smpc_pkg::CMD_WR_WORD, smpc_pkg::CMD_FETCH:
            begin
                lane_mask  = 4'b1111;
                misaligned = (addr_reg[1:0] != 2'b00);
            end
            default:
            begin
                lane_mask = '0;
            end
        endcase

        unique case (cmd_reg) inside
            smpc_pkg::CMD_RD_BYTE, smpc_pkg::CMD_RD_HALF, smpc_pkg::CMD_RD_WORD:
            begin
                if (misaligned)
                    err_next = smpc_pkg::ERR_MISALIGNED;
                else if ((lane_mask & ~lane_rd_ok) != '0)
                    err_next = smpc_pkg::ERR_READ_DENIED;
            end
            smpc_pkg::CMD_WR_BYTE, smpc_pkg::CMD_WR_HALF, smpc_pkg::CMD_WR_WORD:
            begin
                is_write = 1'b1;
                if (misaligned)
                    err_next = smpc_pkg::ERR_MISALIGNED;
                else if ((lane_mask & ~lane_wr_ok) != '0)
                    err_next = smpc_pkg::ERR_WRITE_DENIED;
            end
            smpc_pkg::CMD_FETCH:
            begin
                if (misaligned)
                    err_next = smpc_pkg::ERR_MISALIGNED;
                else if (!lane_hit[0] || !lane_perms[0][smpc_pkg::PERM_EXEC_BIT])
                    err_next = smpc_pkg::ERR_NOT_EXEC;
                else if (fetch_last >= first_end)
                    err_next = smpc_pkg::ERR_FETCH_OOB;
            end
            default:
            begin
                if (table_full)
                    err_next = smpc_pkg::ERR_TABLE_FULL;
            end
        endcase
    end

    // a failing access writes nothing
    assign mem_we     = (is_write && (err_next == smpc_pkg::ERR_OK)) ? lane_mask : '0;
    assign region_add = (cmd_reg == smpc_pkg::CMD_ADD_SEG) && !table_full;

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            err_reg     <= err_next;
            rd_word_reg <= mem_reg[word_idx];
            for (int k = 0; k < NL; k++)
            begin
                if (mem_we[k])
                    mem_reg[word_idx][k*8 +: 8] <= wlane_data[k*8 +: 8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute && region_add)
        begin
            region_base_reg[region_count_reg[IW-1:0]]  <= seg_base_reg;
            region_end_reg[region_count_reg[IW-1:0]]   <= {2'b00, seg_base_reg}
                                                          + {1'b0, seg_len_reg};
            region_perms_reg[region_count_reg[IW-1:0]] <= seg_perms_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_valid_reg <= '0;
            region_count_reg <= '0;
        end
        else if (ctrl.execute && region_add)
        begin
            region_valid_reg[region_count_reg[IW-1:0]] <= 1'b1;
            region_count_reg <= region_count_reg + CW'(1);
        end
    end

    // align and zero-extend the loaded word
    assign rd_shift = rd_word_reg >> {addr_reg[1:0], 3'b000};

    always_comb
    begin
        read_data_next = '0;
        if (err_reg == smpc_pkg::ERR_OK)
        begin
            case (cmd_reg)
                smpc_pkg::CMD_RD_BYTE: read_data_next = {24'b0, rd_shift[7:0]};
                smpc_pkg::CMD_RD_HALF: read_data_next = {16'b0, rd_shift[15:0]};
                smpc_pkg::CMD_RD_WORD: read_data_next = rd_word_reg;
                smpc_pkg::CMD_FETCH:   read_data_next = rd_word_reg;
                default:               read_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            read_data_reg  <= read_data_next;
            error_code_reg <= err_reg;
        end
    end

    assign read_data  = read_data_reg;
    assign error_code = error_code_reg;

endmodule

>>> rtl/core/segmented_memory_permission_check_unit.sv
// ----------------------------------------------------------------------------
// segmented_memory_permission_check_unit
// Byte memory guarded by a segment table with read/write/execute checks.
// ----------------------------------------------------------------------------
// Usage:
//   A request (command, address, write_data, new_seg_*) enters on the
//   in_valid/in_ready channel; one result (read_data, error_code) leaves
//   on the out_valid/out_ready channel for every request, in order.
//   Each request passes through capture, segment match plus one access of
//   the single memory port, then the result load. A new request is taken
//   once the previous one has left its load step, even while that result
//   still sits in the output register.
//   If the receiver stalls, the result stays in the output register and a
//   following request waits in its load step until that register frees.
//   The segment table is matched in parallel against all four bytes of the
//   addressed word.
//   Reset empties the segment table (count and valid bits); memory contents
//   are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
module segmented_memory_permission_check_unit #(
    parameter int ADDR_BITS   = 16,
    parameter int MAX_REGIONS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [15:0] address,
    input  logic [31:0] write_data,
    input  logic [15:0] new_seg_base,
    input  logic [16:0] new_seg_size,
    input  logic [2:0]  new_seg_perms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [2:0]  error_code
);

    smpc_pkg::dp_ctrl_t ctrl;

    smpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    smpc_datapath #(
        .ADDR_BITS   (ADDR_BITS),
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .command       (command),
        .address       (address),
        .write_data    (write_data),
        .new_seg_base  (new_seg_base),
        .new_seg_size  (new_seg_size),
        .new_seg_perms (new_seg_perms),
        .read_data     (read_data),
        .error_code    (error_code)
    );

    // one request in flight at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // a failing request returns zero data
    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != smpc_pkg::ERR_OK)) |-> (read_data == 32'd0))
        else $error("nonzero read data with an error code");

    // a new result appears only at the end of a request's load step
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while the unit was idle");

    a_no_busy_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 !$rose(out_valid))
        else $error("result published before the check step ran");

endmodule

>>> test/segmented_memory_permission_check_unit_tb.sv
// ----------------------------------------------------------------------------
// segmented_memory_permission_check_unit_tb
// Self-checking bench for the segment-guarded byte memory. A directed
// sequence writes memory, fills the segment table and probes every error
// path. Random requests then run under several sender and receiver
// throttling mixes. Each result is checked against an in-bench predictor
// that keeps its own memory image and segment table.
// ----------------------------------------------------------------------------
module segmented_memory_permission_check_unit_tb;

    localparam int SEG_SLOTS     = 4;
    localparam int RECENT_DEPTH  = 64;
    localparam int PHASE_ITEMS   = 460;
    localparam int TIMEOUT_TICKS = 4000000;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        logic [31:0]    rdata;
        smpc_pkg::err_t err;
    } resp_t;

    typedef struct {
        smpc_pkg::cmd_t cmd;
        logic [15:0]    addr;
        logic [31:0]    wdata;
        logic [15:0]    seg_base;
        logic [16:0]    seg_size;
        logic [2:0]     seg_perms;
        resp_t          want;
    } request_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [2:0]  command       = '0;
    logic [15:0] address       = '0;
    logic [31:0] write_data    = '0;
    logic [15:0] new_seg_base  = '0;
    logic [16:0] new_seg_size  = '0;
    logic [2:0]  new_seg_perms = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] read_data;
    logic [2:0]  error_code;

    // Predictor state: memory image and segment table
    logic [7:0]  mem_model   [0:65535];
    bit          mem_written [0:65535];
    logic [15:0] seg_base    [SEG_SLOTS];
    logic [16:0] seg_len     [SEG_SLOTS];
    logic [2:0]  seg_perm    [SEG_SLOTS];
    int          seg_count = 0;
    logic [15:0] written_spots [$];

    request_t pending_requests [$];
    resp_t    expected_results [$];
    request_t in_flight;
    resp_t    oldest_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int code_seen [8];

    segmented_memory_permission_check_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .address       (address),
        .write_data    (write_data),
        .new_seg_base  (new_seg_base),
        .new_seg_size  (new_seg_size),
        .new_seg_perms (new_seg_perms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .error_code    (error_code)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic int access_bytes(input smpc_pkg::cmd_t c);
        case (c)
            smpc_pkg::CMD_RD_HALF, smpc_pkg::CMD_WR_HALF: return 2;
            smpc_pkg::CMD_RD_WORD, smpc_pkg::CMD_WR_WORD,
            smpc_pkg::CMD_FETCH:                          return 4;
            default:                                      return 1;
        endcase
    endfunction

    // Segment end is two bits wider than an address, so it never wraps
    function automatic int first_segment(input logic [15:0] a);
        logic [17:0] seg_end;
        for (int i = 0; i < seg_count; i++)
        begin
            seg_end = {2'b00, seg_base[i]} + {1'b0, seg_len[i]};
            if (a >= seg_base[i] && {2'b00, a} < seg_end)
                return i;
        end
        return -1;
    endfunction

    function automatic bit bytes_allowed(input logic [15:0] a, input int nb,
                                         input int perm_bit);
        int s;
        for (int k = 0; k < nb; k++)
        begin
            s = first_segment(a + 16'(k));
            if (s >= 0 && !seg_perm[s][perm_bit])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] load_bytes(input logic [15:0] a, input int nb,
                                               inout bit unread);
        logic [31:0] v;
        logic [15:0] p;
        v = '0;
        for (int k = 0; k < nb; k++)
        begin
            p = a + 16'(k);
            if (!mem_written[p])
                unread = 1'b1;
            v[8*k +: 8] = mem_model[p];
        end
        return v;
    endfunction

    // Work out the result of one request and commit its effect. Returns 1 when
    // a successful load would touch never-written bytes; such a request has
    // no effect and must be dropped by the caller.
    function automatic bit predict_request(input request_t r, output resp_t res);
        int          nb;
        int          s;
        bit          unread;
        logic [17:0] last_byte;
        res.rdata = '0;
        res.err   = smpc_pkg::ERR_OK;
        unread    = 1'b0;
        nb        = access_bytes(r.cmd);
        case (r.cmd)
            smpc_pkg::CMD_ADD_SEG:
            begin
                if (seg_count >= SEG_SLOTS)
                    res.err = smpc_pkg::ERR_TABLE_FULL;
                else
                begin
                    seg_base[seg_count] = r.seg_base;
                    seg_len[seg_count]  = r.seg_size;
                    seg_perm[seg_count] = r.seg_perms;
                    seg_count++;
                end
            end
            smpc_pkg::CMD_FETCH:
            begin
                s = first_segment(r.addr);
                last_byte = {2'b00, r.addr} + 18'd3;
                if (r.addr[1:0] != 2'b00)
                    res.err = smpc_pkg::ERR_MISALIGNED;
                else if (s < 0 || !seg_perm[s][smpc_pkg::PERM_EXEC_BIT])
                    res.err = smpc_pkg::ERR_NOT_EXEC;
                else if (last_byte >= {2'b00, seg_base[s]} + {1'b0, seg_len[s]})
                    res.err = smpc_pkg::ERR_FETCH_OOB;
                else
                    res.rdata = load_bytes(r.addr, 4, unread);
            end
            smpc_pkg::CMD_RD_BYTE, smpc_pkg::CMD_RD_HALF, smpc_pkg::CMD_RD_WORD:
            begin
                if ((r.addr & 16'(nb - 1)) != 16'd0)
                    res.err = smpc_pkg::ERR_MISALIGNED;
                else if (!bytes_allowed(r.addr, nb, smpc_pkg::PERM_READ_BIT))
                    res.err = smpc_pkg::ERR_READ_DENIED;
                else
                    res.rdata = load_bytes(r.addr, nb, unread);
            end
            default:
            begin
                if ((r.addr & 16'(nb - 1)) != 16'd0)
                    res.err = smpc_pkg::ERR_MISALIGNED;
                else if (!bytes_allowed(r.addr, nb, smpc_pkg::PERM_WRITE_BIT))
                    res.err = smpc_pkg::ERR_WRITE_DENIED;
                else
                begin
                    for (int k = 0; k < nb; k++)
                    begin
                        mem_model[r.addr + 16'(k)]   = r.wdata[8*k +: 8];
                        mem_written[r.addr + 16'(k)] = 1'b1;
                    end
                    written_spots.push_back(r.addr);
                    if (written_spots.size() > RECENT_DEPTH)
                        void'(written_spots.pop_front());
                end
            end
        endcase
        return unread;
    endfunction

    task automatic queue_request(input smpc_pkg::cmd_t c, input logic [15:0] a,
                                 input logic [31:0] d, input logic [15:0] b,
                                 input logic [16:0] sz, input logic [2:0] pm);
        request_t r;
        r.cmd       = c;
        r.addr      = a;
        r.wdata     = d;
        r.seg_base  = b;
        r.seg_size  = sz;
        r.seg_perms = pm;
        void'(predict_request(r, r.want));
        pending_requests.push_back(r);
    endtask

    function automatic request_t random_request();
        request_t r;
        int       nb;
        int       pick;
        bit       loads;
        logic [15:0] a;
        r.wdata      = $urandom();
        r.seg_base   = 16'($urandom());
        r.seg_size   = 17'($urandom_range(65536));
        r.seg_perms  = 3'($urandom_range(7));
        r.want.rdata = '0;
        r.want.err   = smpc_pkg::ERR_OK;
        if ($urandom_range(99) < 4)
            r.cmd = smpc_pkg::CMD_ADD_SEG;
        else
            r.cmd = smpc_pkg::cmd_t'($urandom_range(6));
        nb    = access_bytes(r.cmd);
        loads = (r.cmd <= smpc_pkg::CMD_RD_WORD) || (r.cmd == smpc_pkg::CMD_FETCH);
        pick  = $urandom_range(99);
        // Aim loads mostly at recently written spots so they return data
        if (loads && pick < 55 && written_spots.size() > 0)
            a = written_spots[$urandom_range(written_spots.size() - 1)];
        else if (pick < 75)
            a = 16'($urandom_range(16'h01FF));
        else if (pick < 87)
            a = 16'hFFC0 + 16'($urandom_range(63));
        else
            a = 16'($urandom());
        if ($urandom_range(9) != 0)
            a = a & ~16'(nb - 1);
        r.addr = a;
        return r;
    endfunction

    task automatic queue_random_request();
        request_t r;
        bit       unsafe;
        unsafe = 1'b1;
        for (int tries = 0; tries < 24 && unsafe; tries++)
        begin
            r = random_request();
            unsafe = predict_request(r, r.want);
        end
        // Turn a load that keeps hitting unwritten bytes into a store
        if (unsafe)
        begin
            r.cmd = smpc_pkg::CMD_WR_WORD;
            void'(predict_request(r, r.want));
        end
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) queue_random_request();
        wait_drained();
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            command       <= '0;
            address       <= '0;
            write_data    <= '0;
            new_seg_base  <= '0;
            new_seg_size  <= '0;
            new_seg_perms <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_results.push_back(in_flight.want);
                accepted_count++;
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_flight      = pending_requests.pop_front();
                in_valid      <= 1'b1;
                command       <= in_flight.cmd;
                address       <= in_flight.addr;
                write_data    <= in_flight.wdata;
                new_seg_base  <= in_flight.seg_base;
                new_seg_size  <= in_flight.seg_size;
                new_seg_perms <= in_flight.seg_perms;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                code_seen[error_code]++;
                if (expected_results.size() == 0)
                    flag_error($sformatf("result with no request outstanding: err %0d data %h",
                                         error_code, read_data));
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (read_data !== oldest_result.rdata)
                        flag_error($sformatf("result %0d read_data %h, expected %h",
                                             result_count, read_data, oldest_result.rdata));
                    if (error_code !== oldest_result.err)
                        flag_error($sformatf("result %0d error_code %0d, expected %0d",
                                             result_count, error_code, oldest_result.err));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_TICKS);
        $display("segmented_memory_permission_check_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: reads and writes can fail only on alignment, fetches also as not executable
        queue_request(smpc_pkg::CMD_WR_WORD, 16'h0040, 32'hFFFF_FFFF, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_WORD, 16'h007C, 32'h89AB_CDEF, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_HALF, 16'h0001, 32'h0000_1234, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_WORD, 16'h0002, 32'h5555_AAAA, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_BYTE, 16'hFFFF, 32'h0000_00A5, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_WORD, 16'hFFFC, 32'hDEAD_BEEF, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_WORD, 16'h0000, 32'h7654_3210, '0, '0, '0);
        queue_request(smpc_pkg::CMD_RD_BYTE, 16'hFFFF, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_RD_HALF, 16'h0041, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_RD_WORD, 16'h0040, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_FETCH,   16'h0042, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_FETCH,   16'h0040, '0, '0, '0, '0);
        // Read/exec window with an end off a word boundary, a write-only segment under it,
        // an exec/write segment that runs past the top, an empty one
        queue_request(smpc_pkg::CMD_ADD_SEG, '0, '0, 16'h0040, 17'h0003E, 3'b101);
        queue_request(smpc_pkg::CMD_ADD_SEG, '0, '0, 16'h0000, 17'h00100, 3'b010);
        queue_request(smpc_pkg::CMD_ADD_SEG, '0, '0, 16'hFFF0, 17'h10000, 3'b110);
        queue_request(smpc_pkg::CMD_ADD_SEG, '0, '0, 16'h3000, 17'h00000, 3'b111);
        queue_request(smpc_pkg::CMD_ADD_SEG, '0, '0, 16'hFFFF, 17'h10000, 3'b111);
        queue_request(smpc_pkg::CMD_RD_WORD, 16'h0040, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_RD_WORD, 16'h007C, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_FETCH,   16'h0040, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_FETCH,   16'h007C, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_BYTE, 16'h0040, 32'h0000_0011, '0, '0, '0);
        queue_request(smpc_pkg::CMD_FETCH,   16'hFFFC, '0, '0, '0, '0);
        queue_request(smpc_pkg::CMD_WR_BYTE, 16'h3000, 32'h0000_005A, '0, '0, '0);
        queue_request(smpc_pkg::CMD_RD_BYTE, 16'h3000, '0, '0, '0, '0);
        wait_drained();

        run_phase(0, 0);
        run_phase(87, 0);
        run_phase(0, 87);
        run_phase(24, 24);

        repeat (16) @(posedge clk);
        $display("Checked %0d results for %0d requests (directed, then four throttling mixes).",
                 result_count, accepted_count);
        $display("Codes: ok %0d, misaligned %0d, rd-denied %0d, wr-denied %0d,",
                 code_seen[smpc_pkg::ERR_OK], code_seen[smpc_pkg::ERR_MISALIGNED],
                 code_seen[smpc_pkg::ERR_READ_DENIED], code_seen[smpc_pkg::ERR_WRITE_DENIED]);
        $display("       not-exec %0d, fetch-oob %0d, table-full %0d",
                 code_seen[smpc_pkg::ERR_NOT_EXEC], code_seen[smpc_pkg::ERR_FETCH_OOB],
                 code_seen[smpc_pkg::ERR_TABLE_FULL]);
        if (error_count == 0)
            $display("segmented_memory_permission_check_unit_tb: done, clean");
        else
            $display("segmented_memory_permission_check_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> segmented_memory_permission_check_unit.f
rtl/core/smpc_pkg.sv
rtl/core/smpc_ctrl.sv
rtl/core/smpc_datapath.sv
rtl/core/segmented_memory_permission_check_unit.sv
test/segmented_memory_permission_check_unit_tb.sv
